>>> design/akst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akst_pkg: shared types and constants of the aged keyed slot table
// Operation and status codes, the input/result payloads and the slot record.
// ----------------------------------------------------------------------------
package akst_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned TimeoutW = 31;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TimeoutW-1:0] TimeoutReset = 31'd5000;

  // register index as decoded from paddr[2]
  localparam logic RegTimeout = 1'b0;

  typedef enum logic [1:0] {
    MODE_UPSERT = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } akst_mode_e;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_DROPPED   = 3'd2,
    STAT_READ_HIT  = 3'd3,
    STAT_READ_MISS = 3'd4,
    STAT_DONE      = 3'd5
  } akst_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_WRITE = 2'd2,
    FSM_RESP  = 2'd3
  } akst_fsm_e;

  typedef struct packed {
    logic [WordW-1:0] key;
    logic [WordW-1:0] pos_x;
    logic [WordW-1:0] pos_y;
    logic [WordW-1:0] pos_z;
    logic [WordW-1:0] heading;
    logic [WordW-1:0] tilt;
    logic [WordW-1:0] last_seen;
  } akst_slot_t;

  typedef struct packed {
    akst_mode_e        mode;
    logic [WordW-1:0]  now_ms;
    logic [WordW-1:0]  session_id;
    logic [WordW-1:0]  pos_x;
    logic [WordW-1:0]  pos_y;
    logic [WordW-1:0]  pos_z;
    logic [WordW-1:0]  heading;
    logic [WordW-1:0]  tilt;
    logic [IndexW-1:0] read_index;
  } akst_in_t;

  typedef struct packed {
    akst_status_e      status;
    logic [CountW-1:0] occupied_count;
    logic [WordW-1:0]  out_session_id;
    logic [WordW-1:0]  out_pos_x;
    logic [WordW-1:0]  out_pos_y;
    logic [WordW-1:0]  out_pos_z;
    logic [WordW-1:0]  out_heading;
    logic [WordW-1:0]  out_tilt;
  } akst_out_t;

endpackage
`default_nettype wire

>>> design/akst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akst_if: valid/ready channels of the aged keyed slot table
// One interface for the request channel, one for the result channel.
// ----------------------------------------------------------------------------
interface akst_in_if;
  logic               valid;
  logic               ready;
  akst_pkg::akst_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface akst_out_if;
  logic                valid;
  logic                ready;
  akst_pkg::akst_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/akst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// akst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module akst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/aged_keyed_slot_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aged_keyed_slot_table_top: keyed slot table with age-out
// Associative table of SLOTS entries keyed by a 32-bit session id, scanned
// one slot per cycle by a small sequencer around one shared subtractor.
// ----------------------------------------------------------------------------
// Each request transaction carries a mode: upsert (rewrite the occupied slot
// whose key matches, else claim the lowest free slot, else drop), tick (free
// every slot whose age now_ms - last_seen, modulo 2^32, is at or above
// timeout_ms), read (return the read_index-th occupied slot in slot order)
// or clear (free every slot). Every request yields exactly one result
// transaction with a status and the occupied count after the request; key and
// payload fields are zero except on a read hit. Slot records live in one RAM
// with registered read; occupancy is a row of flip-flops cleared at reset, so
// no clearing pass is needed. Upsert, tick and read walk all SLOTS slots
// through the RAM read port, one slot per cycle. After the scan an upsert
// goes through a write state that writes the slot before the result is
// posted; a tick or read posts its result straight after the scan, and a
// clear posts its result with no scan. Once the result is posted the block
// returns to idle, where the next request can be accepted. The block takes
// one request at a time: in_i.ready is high only while idle. A finished
// result sits in an output register, so the next request can be accepted
// while the previous result is still waiting downstream; if that result is
// still waiting when the next one is done, the block holds in its response
// state until it is taken. timeout_ms is written over APB at byte address 0
// and should only change while idle.
// ----------------------------------------------------------------------------
module aged_keyed_slot_table_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [akst_pkg::ApbAddrW-1:0]   paddr,
  input  logic [akst_pkg::ApbDataW-1:0]   pwdata,
  output logic [akst_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  // request and result channels
  akst_in_if.sink                         in_i,
  akst_out_if.source                      out_o
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned SlotW = $bits(akst_pkg::akst_slot_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  akst_pkg::akst_fsm_e   state_q, state_d;
  logic [akst_pkg::TimeoutW-1:0] timeout_q, timeout_d;
  logic [SLOTS-1:0]      valid_q, valid_d;     // slot occupied
  logic [CntW-1:0]       count_q, count_d;     // occupied slots

  // scan pipeline: issue stage drives the RAM address, check stage sees data
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  issue_q, issue_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]       chk_idx_q, chk_idx_d;

  // scan results
  logic                  hit_q, hit_d;
  logic [IdxW-1:0]       hit_idx_q, hit_idx_d;
  logic                  free_q, free_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic                  found_q, found_d;
  logic [CntW-1:0]       rank_q, rank_d;       // occupied slots passed by a read

  // transaction payload registers
  akst_pkg::akst_in_t     req_q, req_d;
  akst_pkg::akst_slot_t   data_q, data_d;
  akst_pkg::akst_status_e status_q, status_d;

  // output register
  logic                  out_vld_q, out_vld_d;
  akst_pkg::akst_out_t   out_q, out_d;

  // RAM port
  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  akst_pkg::akst_slot_t  ram_wdata;
  akst_pkg::akst_slot_t  ram_rdata;

  // shared subtractor: key compare on upsert, age on tick
  logic [akst_pkg::WordW-1:0] alu_a, alu_b, alu_diff;
  logic                       key_match, aged;

  logic cfg_wr;

  // --------------------------------------------------------------------------
  // Slot RAM
  // --------------------------------------------------------------------------
  akst_ram #(
    .Width (SlotW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // a claimed or refreshed slot is rewritten whole
  assign ram_wdata = '{
    key:       req_q.session_id,
    pos_x:     req_q.pos_x,
    pos_y:     req_q.pos_y,
    pos_z:     req_q.pos_z,
    heading:   req_q.heading,
    tilt:      req_q.tilt,
    last_seen: req_q.now_ms
  };

  // --------------------------------------------------------------------------
  // Shared subtract/compare unit
  // --------------------------------------------------------------------------
  always_comb begin
    if (req_q.mode == akst_pkg::MODE_TICK) begin
      alu_a = req_q.now_ms;
      alu_b = ram_rdata.last_seen;
    end else begin
      alu_a = req_q.session_id;
      alu_b = ram_rdata.key;
    end
  end

  assign alu_diff  = alu_a - alu_b;                 // modular age on tick
  assign key_match = (alu_diff == '0);
  assign aged      = (alu_diff >= {1'b0, timeout_q});

  // --------------------------------------------------------------------------
  // APB register
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[akst_pkg::ApbAddrW-1] == akst_pkg::RegTimeout);
  assign timeout_d = cfg_wr ? pwdata[akst_pkg::TimeoutW-1:0] : timeout_q;
  assign prdata = (paddr[akst_pkg::ApbAddrW-1] == akst_pkg::RegTimeout) ?
                  {1'b0, timeout_q} : '0;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_i.ready    = (state_q == akst_pkg::FSM_IDLE);
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    issue_d    = issue_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    found_d    = found_q;
    rank_d     = rank_q;
    req_d      = req_q;
    data_d     = data_q;
    status_d   = status_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;

    // result taken downstream
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      akst_pkg::FSM_IDLE: begin
        if (in_i.valid) begin
          req_d     = in_i.payload;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          found_d   = 1'b0;
          rank_d    = '0;
          rd_idx_d  = '0;
          chk_vld_d = 1'b0;
          if (in_i.payload.mode == akst_pkg::MODE_CLEAR) begin
            valid_d  = '0;
            count_d  = '0;
            status_d = akst_pkg::STAT_DONE;
            issue_d  = 1'b0;
            state_d  = akst_pkg::FSM_RESP;
          end else begin
            issue_d = 1'b1;
            state_d = akst_pkg::FSM_SCAN;
          end
        end
      end

      akst_pkg::FSM_SCAN: begin
        // issue stage
        chk_vld_d = issue_q;
        chk_idx_d = rd_idx_q;
        if (issue_q) begin
          if (rd_idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end

        // check stage: RAM data belongs to chk_idx_q
        if (chk_vld_q) begin
          case (req_q.mode)
            akst_pkg::MODE_UPSERT: begin
              if (valid_q[chk_idx_q] && key_match && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = chk_idx_q;
              end
              if (!valid_q[chk_idx_q] && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = chk_idx_q;
              end
            end
            akst_pkg::MODE_TICK: begin
              if (valid_q[chk_idx_q] && aged) begin
                valid_d[chk_idx_q] = 1'b0;
                count_d            = count_q - 1'b1;
              end
            end
            akst_pkg::MODE_READ: begin
              if (valid_q[chk_idx_q]) begin
                if (!found_q && (akst_pkg::CountW'(rank_q) ==
                                 akst_pkg::CountW'(req_q.read_index))) begin
                  found_d = 1'b1;
                  data_d  = ram_rdata;
                end
                rank_d = rank_q + 1'b1;
              end
            end
            default: ;
          endcase

          if (chk_idx_q == LastIdx) begin
            if (req_q.mode == akst_pkg::MODE_UPSERT) begin
              state_d = akst_pkg::FSM_WRITE;
            end else begin
              state_d = akst_pkg::FSM_RESP;
            end
            if (req_q.mode == akst_pkg::MODE_READ) begin
              status_d = found_d ? akst_pkg::STAT_READ_HIT : akst_pkg::STAT_READ_MISS;
            end else begin
              status_d = akst_pkg::STAT_DONE;
            end
          end
        end
      end

      akst_pkg::FSM_WRITE: begin
        // matching slot wins over the lowest free one
        if (hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          status_d  = akst_pkg::STAT_UPDATED;
        end else if (free_q) begin
          ram_we              = 1'b1;
          ram_waddr           = free_idx_q;
          valid_d[free_idx_q] = 1'b1;
          count_d             = count_q + 1'b1;
          status_d            = akst_pkg::STAT_INSERTED;
        end else begin
          status_d = akst_pkg::STAT_DROPPED;
        end
        state_d = akst_pkg::FSM_RESP;
      end

      akst_pkg::FSM_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d            = 1'b1;
          out_d.status         = status_q;
          out_d.occupied_count = akst_pkg::CountW'(count_q);
          if (status_q == akst_pkg::STAT_READ_HIT) begin
            out_d.out_session_id = data_q.key;
            out_d.out_pos_x      = data_q.pos_x;
            out_d.out_pos_y      = data_q.pos_y;
            out_d.out_pos_z      = data_q.pos_z;
            out_d.out_heading    = data_q.heading;
            out_d.out_tilt       = data_q.tilt;
          end else begin
            out_d.out_session_id = '0;
            out_d.out_pos_x      = '0;
            out_d.out_pos_y      = '0;
            out_d.out_pos_z      = '0;
            out_d.out_heading    = '0;
            out_d.out_tilt       = '0;
          end
          state_d = akst_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = akst_pkg::FSM_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= akst_pkg::FSM_IDLE;
      timeout_q <= akst_pkg::TimeoutReset;
      valid_q   <= '0;
      count_q   <= '0;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      timeout_q <= timeout_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload and scan bookkeeping, qualified by the state machine
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    found_q    <= found_d;
    rank_q     <= rank_d;
    req_q      <= req_d;
    data_q     <= data_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire
